[rtl/core/nrl_pkg.sv]
// ----------------------------------------------------------------------------
// nrl_pkg
// shared types and constants of the numeric range list parser
// ----------------------------------------------------------------------------
package nrl_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int OUT_WIDTH       = 64;
    localparam int BASE_WIDTH      = 6;
    localparam int CHAR_WIDTH      = 8;
    localparam int DIGIT_WIDTH     = 6;

    localparam logic [BASE_WIDTH-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_WIDTH-1:0] BASE_MAX   = 6'd36;

    localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_WIDTH-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_WIDTH-1:0] CH_COMMA = 8'h2c;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7a;
    localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5a;

    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE = 6'd63;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FORMAT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_N1_PRE  = 3'd1,
        PH_N1_BODY = 3'd2,
        PH_DOT     = 3'd3,
        PH_N2_PRE  = 3'd4,
        PH_N2_BODY = 3'd5,
        PH_COMMA   = 3'd6,
        PH_SKIP    = 3'd7
    } t_phase;

    typedef struct packed {
        logic dig_ok;
        logic decimal;
        logic sat;
    } t_digit_info;

endpackage

[rtl/core/nrl_accum.sv]
// ----------------------------------------------------------------------------
// nrl_accum
// digit decode and saturating multiply-accumulate by the base
// ----------------------------------------------------------------------------
module nrl_accum
    import nrl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic [CHAR_WIDTH-1:0]  i_char,
    input  logic [BASE_WIDTH-1:0]  i_base,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  logic                   i_neg,
    input  logic                   i_sat,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output t_digit_info            o_info
);

    localparam int PW = VALUE_WIDTH + BASE_WIDTH;

    logic [DIGIT_WIDTH-1:0] digit;
    logic [PW-1:0]          sum;
    logic [PW-1:0]          lim;

    always_comb begin
        if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
            digit = DIGIT_WIDTH'(i_char - CH_ZERO);
        end else if (i_char >= CH_LA && i_char <= CH_LZ) begin
            digit = DIGIT_WIDTH'(i_char - CH_LA + 8'd10);
        end else if (i_char >= CH_UA && i_char <= CH_UZ) begin
            digit = DIGIT_WIDTH'(i_char - CH_UA + 8'd10);
        end else begin
            digit = DIGIT_NONE;
        end
    end

    // mag*base + d > lim is the same test as mag > (lim - d) / base
    assign sum = PW'(i_mag) * PW'(i_base) + PW'(digit);
    assign lim = {{(BASE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}} + PW'(i_neg);

    always_comb begin
        o_info.dig_ok  = digit < i_base;
        o_info.decimal = i_char >= CH_ZERO && i_char <= CH_NINE;
        o_info.sat     = i_sat;
        o_mag          = i_mag;
        if (!i_sat) begin
            if (sum > lim) begin
                o_mag      = lim[VALUE_WIDTH-1:0];
                o_info.sat = 1'b1;
            end else begin
                o_mag = sum[VALUE_WIDTH-1:0];
            end
        end
    end

endmodule

[rtl/core/numeric_range_list_parser.sv]
// ----------------------------------------------------------------------------
// numeric_range_list_parser
// streaming parser of signed integer ranges, one character per word
// ----------------------------------------------------------------------------
// Takes one character per cycle on the input channel and gives at most one
// range word per character; each character passes through the input register,
// the single decode and multiply-accumulate stage and the result register. A
// new character is taken every cycle unless an unread result word holds the
// stage. Values are VALUE_WIDTH-bit two's complement, sign-extended to 64 bits.
// number_base (2 to 36) may only be written while the block is idle; other
// values are ignored.
module numeric_range_list_parser
    import nrl_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_number_base_we,
    input  logic [BASE_WIDTH-1:0]       i_number_base,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [CHAR_WIDTH-1:0]       i_character_code,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_WIDTH-1:0] o_range_low,
    output logic signed [OUT_WIDTH-1:0] o_range_high,
    output logic [1:0]                  o_status,
    output logic                        o_string_end
);

    logic [BASE_WIDTH-1:0]         r_base;
    logic                          r_in_valid;
    logic [CHAR_WIDTH-1:0]         r_char;
    t_phase                        r_phase, n_phase;
    logic signed [VALUE_WIDTH-1:0] r_first, n_first;
    logic [VALUE_WIDTH-1:0]        r_mag, n_mag;
    logic                          r_neg, n_neg;
    logic                          r_seen, n_seen;
    logic                          r_sat, n_sat;
    logic                          r_out_valid;
    logic signed [OUT_WIDTH-1:0]   r_lo, r_hi;
    logic [1:0]                    r_status;
    logic                          r_end;

    logic                          fire;
    logic                          clr;
    logic [VALUE_WIDTH-1:0]        acc_mag;
    t_digit_info                   acc_info;
    logic signed [VALUE_WIDTH-1:0] cur;
    logic signed [VALUE_WIDTH-1:0] pair_lo, pair_hi;
    logic                          is_space, is_sign, is_nul;
    logic                          do_start, do_fail;
    t_phase                        start_body;
    logic                          res_vld;
    logic signed [VALUE_WIDTH-1:0] res_lo, res_hi;
    logic [1:0]                    res_status;
    logic                          res_end;

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign clr        = (r_phase == PH_START) || (r_phase == PH_COMMA);

    nrl_accum #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_accum (
        .i_char (r_char),
        .i_base (r_base),
        .i_mag  (clr ? '0 : r_mag),
        .i_neg  (clr ? 1'b0 : r_neg),
        .i_sat  (clr ? 1'b0 : r_sat),
        .o_mag  (acc_mag),
        .o_info (acc_info)
    );

    assign cur      = r_neg ? -$signed(r_mag) : $signed(r_mag);
    assign pair_lo  = (cur < r_first) ? cur : r_first;
    assign pair_hi  = (cur < r_first) ? r_first : cur;
    assign is_nul   = r_char == CH_NUL;
    assign is_sign  = r_char == CH_PLUS || r_char == CH_MINUS;
    assign is_space = r_char == CH_SPACE || (r_char >= CH_TAB && r_char <= CH_CR);

    // phase decode
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_seen     = r_seen;
        n_sat      = r_sat;
        do_start   = 1'b0;
        do_fail    = 1'b0;
        start_body = PH_N1_BODY;
        res_vld    = 1'b0;
        res_lo     = '0;
        res_hi     = '0;
        res_status = ST_OK;
        res_end    = 1'b0;
        unique case (r_phase)
            PH_START: begin
                if (is_nul) begin
                    res_vld    = 1'b1;
                    res_status = ST_EMPTY;
                    res_end    = 1'b1;
                end else begin
                    n_phase  = PH_N1_PRE;
                    n_mag    = '0;
                    n_neg    = 1'b0;
                    n_seen   = 1'b0;
                    n_sat    = 1'b0;
                    do_start = 1'b1;
                end
            end
            PH_N1_PRE: begin
                do_start = 1'b1;
            end
            PH_N2_PRE: begin
                do_start   = 1'b1;
                start_body = PH_N2_BODY;
            end
            PH_N1_BODY, PH_N2_BODY: begin
                if (acc_info.dig_ok) begin
                    n_mag  = acc_mag;
                    n_sat  = acc_info.sat;
                    n_seen = 1'b1;
                end else if (!r_seen) begin
                    do_fail = 1'b1;
                end else if (is_nul) begin
                    n_phase = PH_START;
                    res_vld = 1'b1;
                    res_end = 1'b1;
                    if (r_phase == PH_N1_BODY) begin
                        res_lo = cur;
                        res_hi = cur;
                    end else begin
                        res_lo = pair_lo;
                        res_hi = pair_hi;
                    end
                end else if (r_phase == PH_N1_BODY &&
                             (r_char == CH_COLON || r_char == CH_DOT)) begin
                    n_first = cur;
                    n_mag   = '0;
                    n_neg   = 1'b0;
                    n_seen  = 1'b0;
                    n_sat   = 1'b0;
                    n_phase = (r_char == CH_COLON) ? PH_N2_PRE : PH_DOT;
                end else if (r_phase == PH_N2_BODY && r_char == CH_COMMA) begin
                    n_phase = PH_COMMA;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_DOT: begin
                if (r_char == CH_DOT) begin
                    n_phase = PH_N2_PRE;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_COMMA: begin
                if (is_sign || (acc_info.decimal && acc_info.dig_ok)) begin
                    res_vld  = 1'b1;
                    res_lo   = pair_lo;
                    res_hi   = pair_hi;
                    n_mag    = '0;
                    n_neg    = 1'b0;
                    n_seen   = 1'b0;
                    n_sat    = 1'b0;
                    n_phase  = PH_N1_PRE;
                    do_start = 1'b1;
                end else begin
                    do_fail = 1'b1;
                end
            end
            PH_SKIP: begin
                if (is_nul) begin
                    n_phase = PH_START;
                    n_mag   = '0;
                    n_neg   = 1'b0;
                    n_seen  = 1'b0;
                    n_sat   = 1'b0;
                end
            end
        endcase

        // start of a number: whitespace, optional sign, first digit
        if (do_start) begin
            if (is_space) begin
                n_phase = n_phase;
            end else if (is_sign) begin
                n_neg   = r_char == CH_MINUS;
                n_phase = start_body;
            end else if (acc_info.dig_ok) begin
                n_mag   = acc_mag;
                n_sat   = acc_info.sat;
                n_seen  = 1'b1;
                n_phase = start_body;
            end else begin
                do_fail = 1'b1;
            end
        end

        if (do_fail) begin
            n_phase    = is_nul ? PH_START : PH_SKIP;
            res_vld    = 1'b1;
            res_lo     = '0;
            res_hi     = '0;
            res_status = ST_FORMAT;
            res_end    = is_nul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_START;
            r_first     <= '0;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_seen      <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_number_base_we && i_number_base >= BASE_MIN &&
                i_number_base <= BASE_MAX) begin
                r_base <= i_number_base;
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_first <= n_first;
                r_mag   <= n_mag;
                r_neg   <= n_neg;
                r_seen  <= n_seen;
                r_sat   <= n_sat;
            end
            if (fire && res_vld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char <= i_character_code;
        end
        if (fire && res_vld) begin
            r_lo     <= OUT_WIDTH'(res_lo);
            r_hi     <= OUT_WIDTH'(res_hi);
            r_status <= res_status;
            r_end    <= res_end;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_range_low  = r_lo;
    assign o_range_high = r_hi;
    assign o_status     = r_status;
    assign o_string_end = r_end;

endmodule

[tb/sv/nrl_range_checker.sv]
// ----------------------------------------------------------------------------
// nrl_range_checker
// predicts and checks the range words of the numeric range list parser
// ----------------------------------------------------------------------------
// Watches the base register port and both channels. Every accepted character
// goes through a local model of the parse state; any word it yields is
// queued, and every accepted output word is compared field by field against
// the oldest queued one. Counts of mismatches and checked words go back to
// the testbench top.
module nrl_range_checker
    import nrl_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_number_base_we,
    input  logic [BASE_WIDTH-1:0]       i_number_base,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [CHAR_WIDTH-1:0]       i_character_code,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [OUT_WIDTH-1:0] i_range_low,
    input  logic signed [OUT_WIDTH-1:0] i_range_high,
    input  logic [1:0]                  i_status,
    input  logic                        i_string_end,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_ranges,
    output int                          o_errors,
    output int                          o_empties
);

    typedef struct packed {
        logic [OUT_WIDTH-1:0] low;
        logic [OUT_WIDTH-1:0] high;
        logic [1:0]           status;
        logic                 str_end;
    } t_range_word;

    t_range_word expected_ranges[$];
    t_range_word next_word;
    t_range_word head_word;

    t_phase                phase;
    logic [63:0]           low_end;
    logic [63:0]           magnitude;
    logic                  minus;
    logic                  has_digit;
    logic                  clipped;
    logic [BASE_WIDTH-1:0] radix;

    int mismatch_count = 0;
    int waiting        = 0;
    int range_count    = 0;
    int error_count    = 0;
    int empty_count    = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = waiting;
    assign o_ranges     = range_count;
    assign o_errors     = error_count;
    assign o_empties    = empty_count;

    function automatic t_range_word pack_word(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [1:0] st, input logic e);
        t_range_word w;
        w.low     = lo;
        w.high    = hi;
        w.status  = st;
        w.str_end = e;
        return w;
    endfunction

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            t = c - CH_ZERO;
            return t[5:0];
        end
        if (c >= CH_LA && c <= CH_LZ) begin
            t = c - CH_LA + 8'd10;
            return t[5:0];
        end
        if (c >= CH_UA && c <= CH_UZ) begin
            t = c - CH_UA + 8'd10;
            return t[5:0];
        end
        return DIGIT_NONE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void restart_number();
        magnitude = '0;
        minus     = 1'b0;
        has_digit = 1'b0;
        clipped   = 1'b0;
    endfunction

    // magnitude limit is one larger for negative numbers
    function automatic void push_digit(input logic [5:0] d);
        logic [63:0] lim;
        lim = 64'h7fff_ffff_ffff_ffff + {63'd0, minus};
        if (!clipped) begin
            if (magnitude > (lim - {58'd0, d}) / {58'd0, radix}) begin
                magnitude = lim;
                clipped   = 1'b1;
            end else begin
                magnitude = magnitude * {58'd0, radix} + {58'd0, d};
            end
        end
        has_digit = 1'b1;
    endfunction

    function automatic logic [63:0] signed_magnitude();
        return minus ? -magnitude : magnitude;
    endfunction

    function automatic bit bad_format(input logic [7:0] c, output t_range_word w);
        phase = (c == CH_NUL) ? PH_START : PH_SKIP;
        w = pack_word('0, '0, ST_FORMAT, c == CH_NUL);
        return 1'b1;
    endfunction

    function automatic t_range_word ordered_range(input logic e);
        logic [63:0] a;
        logic [63:0] b;
        a = low_end;
        b = signed_magnitude();
        if ($signed(b) < $signed(a)) return pack_word(b, a, ST_OK, e);
        return pack_word(a, b, ST_OK, e);
    endfunction

    function automatic bit number_lead(input logic [7:0] c, input t_phase body,
                                       output t_range_word w);
        logic [5:0] d;
        d = digit_value(c);
        if (is_blank(c)) return 1'b0;
        if (c == CH_PLUS || c == CH_MINUS) begin
            minus = (c == CH_MINUS);
            phase = body;
            return 1'b0;
        end
        if (d < radix) begin
            push_digit(d);
            phase = body;
            return 1'b0;
        end
        return bad_format(c, w);
    endfunction

    function automatic bit number_tail(input logic [7:0] c, input bit second,
                                       output t_range_word w);
        logic [5:0] d;
        d = digit_value(c);
        if (d < radix) begin
            push_digit(d);
            return 1'b0;
        end
        if (!has_digit) return bad_format(c, w);
        if (!second) begin
            if (c == CH_NUL) begin
                phase = PH_START;
                w = pack_word(signed_magnitude(), signed_magnitude(), ST_OK, 1'b1);
                return 1'b1;
            end
            if (c == CH_COLON || c == CH_DOT) begin
                low_end = signed_magnitude();
                restart_number();
                phase = (c == CH_COLON) ? PH_N2_PRE : PH_DOT;
                return 1'b0;
            end
            return bad_format(c, w);
        end
        if (c == CH_NUL) begin
            phase = PH_START;
            w = ordered_range(1'b1);
            return 1'b1;
        end
        if (c == CH_COMMA) begin
            phase = PH_COMMA;
            return 1'b0;
        end
        return bad_format(c, w);
    endfunction

    function automatic bit parse_char(input logic [7:0] c, output t_range_word w);
        t_range_word unused;
        bit          dropped;
        case (phase)
            PH_START: begin
                if (c == CH_NUL) begin
                    w = pack_word('0, '0, ST_EMPTY, 1'b1);
                    return 1'b1;
                end
                restart_number();
                phase = PH_N1_PRE;
                return number_lead(c, PH_N1_BODY, w);
            end
            PH_N1_PRE:  return number_lead(c, PH_N1_BODY, w);
            PH_N1_BODY: return number_tail(c, 1'b0, w);
            PH_DOT: begin
                if (c == CH_DOT) begin
                    phase = PH_N2_PRE;
                    return 1'b0;
                end
                return bad_format(c, w);
            end
            PH_N2_PRE:  return number_lead(c, PH_N2_BODY, w);
            PH_N2_BODY: return number_tail(c, 1'b1, w);
            PH_COMMA: begin
                // pending range goes out on the character after the comma
                if (c == CH_PLUS || c == CH_MINUS ||
                    (c >= CH_ZERO && c <= CH_NINE && digit_value(c) < radix)) begin
                    w = ordered_range(1'b0);
                    restart_number();
                    phase = PH_N1_PRE;
                    dropped = number_lead(c, PH_N1_BODY, unused);
                    return 1'b1;
                end
                return bad_format(c, w);
            end
            default: begin
                if (c == CH_NUL) begin
                    phase = PH_START;
                    restart_number();
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name,
                     $signed(want), $signed(got));
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase   = PH_START;
            low_end = '0;
            restart_number();
            radix   = BASE_RESET;
            expected_ranges.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_ranges.size() == 0) begin
                    $display("%0t: range word expected none actual %0d %0d %0d %0b",
                             $time, i_range_low, i_range_high, i_status, i_string_end);
                    mismatch_count++;
                end else begin
                    head_word = expected_ranges.pop_front();
                    check_field("range_low", head_word.low, i_range_low);
                    check_field("range_high", head_word.high, i_range_high);
                    check_field("status", {62'd0, head_word.status}, {62'd0, i_status});
                    check_field("string_end", {63'd0, head_word.str_end},
                                {63'd0, i_string_end});
                    case (head_word.status)
                        ST_OK:     range_count++;
                        ST_FORMAT: error_count++;
                        default:   empty_count++;
                    endcase
                end
            end
            if (i_number_base_we && i_number_base >= BASE_MIN && i_number_base <= BASE_MAX) begin
                radix = i_number_base;
            end
            if (i_in_valid && i_in_ready) begin
                if (parse_char(i_character_code, next_word)) expected_ranges.push_back(next_word);
            end
        end
        waiting = expected_ranges.size();
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the numeric range list parser
// ----------------------------------------------------------------------------
// Feeds NUL-terminated strings one character per word: a few directed
// strings, then phases of random range lists in several bases, including
// the extremes 2 and 36, saturating and boundary values, broken strings and
// noise. Both channels stall at random outside the quiet base-36 phase; the base
// is rewritten, with invalid values too, only after all pending words have come back.
module tb;
    import nrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int IDLE_PCT       = 13;
    localparam int TARGET_CHARS   = 720;
    localparam int PHASE_CHARS    = 120;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_number_base_we;
    logic [BASE_WIDTH-1:0]       i_number_base;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [CHAR_WIDTH-1:0]       i_character_code;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic signed [OUT_WIDTH-1:0] o_range_low;
    logic signed [OUT_WIDTH-1:0] o_range_high;
    logic [1:0]                  o_status;
    logic                        o_string_end;

    int mismatches;
    int pending;
    int ranges;
    int errors;
    int empties;

    int                    chars_sent    = 0;
    int                    strings_sent  = 0;
    int                    base_settings = 1;
    int                    idle_cycles   = 0;
    int                    phase_start;
    int                    pick;
    bit                    quiet         = 1'b0;
    logic [BASE_WIDTH-1:0] cur_base      = BASE_RESET;
    logic [7:0]            text_q[$];

    numeric_range_list_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_number_base_we (i_number_base_we),
        .i_number_base    (i_number_base),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_character_code (i_character_code),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_range_low      (o_range_low),
        .o_range_high     (o_range_high),
        .o_status         (o_status),
        .o_string_end     (o_string_end)
    );

    nrl_range_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_number_base_we (i_number_base_we),
        .i_number_base    (i_number_base),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_character_code (i_character_code),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_range_low      (o_range_low),
        .i_range_high     (o_range_high),
        .i_status         (o_status),
        .i_string_end     (o_string_end),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_ranges         (ranges),
        .o_errors         (errors),
        .o_empties        (empties)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("FAIL numeric_range_list_parser");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] ch);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_character_code <= ch;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_char(text_q[i]);
        strings_sent++;
    endtask

    task automatic send_string(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        text_q.push_back(CH_NUL);
        send_text();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base(input logic [BASE_WIDTH-1:0] v);
        i_number_base_we <= 1'b1;
        i_number_base    <= v;
        @(negedge i_clk);
        i_number_base_we <= 1'b0;
        @(negedge i_clk);
        if (v >= BASE_MIN && v <= BASE_MAX) cur_base = v;
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'(CH_ZERO + d);
        return 8'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    function automatic void add_number(input bit after_comma);
        int          len;
        int          lead_max;
        logic [63:0] m;
        logic [7:0]  digs[$];
        lead_max = (cur_base < 10) ? cur_base - 1 : 9;
        if (!after_comma && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2))
                text_q.push_back(($urandom_range(5) == 0) ? CH_SPACE :
                                 8'(CH_TAB + $urandom_range(4)));
        end
        case ($urandom_range(3))
            0:       text_q.push_back(CH_MINUS);
            1:       text_q.push_back(CH_PLUS);
            default: ;
        endcase
        if ($urandom_range(11) == 0) begin
            // magnitudes right at and just past the signed limit
            m = 64'h8000_0000_0000_0000 + $urandom_range(2) - 1;
            while (m != 0) begin
                digs.push_front(digit_char(int'(m % cur_base)));
                m = m / cur_base;
            end
            foreach (digs[i]) text_q.push_back(digs[i]);
        end else begin
            len = ($urandom_range(9) == 0) ?
                  ((cur_base <= 3) ? 66 : (cur_base <= 7) ? 34 : (cur_base <= 15) ? 24 : 18) :
                  $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                text_q.push_back(digit_char((i == 0 && after_comma) ?
                                            $urandom_range(lead_max) :
                                            $urandom_range(cur_base - 1)));
            end
        end
    endfunction

    function automatic void add_list();
        int count;
        count = $urandom_range(1, 3);
        for (int r = 0; r < count; r++) begin
            add_number(r > 0);
            if (r == count - 1 && $urandom_range(2) == 0) break;
            if ($urandom_range(1)) begin
                text_q.push_back(CH_COLON);
            end else begin
                text_q.push_back(CH_DOT);
                text_q.push_back(CH_DOT);
            end
            add_number(1'b0);
            if (r < count - 1) begin
                text_q.push_back(CH_COMMA);
                if ($urandom_range(9) == 0) begin
                    // digit not allowed after a comma in this base
                    text_q.push_back((cur_base < 10) ?
                                     8'(CH_ZERO + $urandom_range(9, cur_base)) :
                                     8'(CH_LA + $urandom_range(25)));
                    break;
                end
            end
        end
        text_q.push_back(CH_NUL);
    endfunction

    initial begin
        i_rst_n          = 1'b0;
        i_number_base_we = 1'b0;
        i_number_base    = BASE_RESET;
        i_in_valid       = 1'b0;
        i_character_code = '0;
        i_out_ready      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_string("");
        send_string("5:-3,+7");
        send_string("1,");
        text_q.delete();
        text_q.push_back(8'hff);
        text_q.push_back(CH_NUL);
        send_text();
        send_string("-");
        send_string(" 2..1");

        for (int ph = 0; chars_sent < TARGET_CHARS; ph++) begin
            drain();
            if (ph == 0 || $urandom_range(1)) begin
                write_base(($urandom_range(3) == 0) ? BASE_WIDTH'($urandom_range(1)) :
                           BASE_WIDTH'(BASE_MAX + 1 + $urandom_range(26)));
            end
            case (ph)
                0:       write_base(BASE_MIN);
                1:       write_base(BASE_MAX);
                2:       write_base(6'd16);
                3:       write_base(6'd8);
                4:       write_base(6'd3);
                default: write_base(BASE_WIDTH'($urandom_range(BASE_MIN, BASE_MAX)));
            endcase
            base_settings++;
            quiet = (ph == 1);
            phase_start = chars_sent;
            while (chars_sent - phase_start < PHASE_CHARS) begin
                text_q.delete();
                pick = $urandom_range(99);
                if (pick < 12) begin
                    repeat ($urandom_range(5)) text_q.push_back(8'($urandom_range(255)));
                    text_q.push_back(CH_NUL);
                end else begin
                    add_list();
                    if ($urandom_range(99) < 15)
                        text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(255));
                    if ($urandom_range(99) < 5) text_q.pop_back();
                end
                send_text();
            end
            send_char(CH_NUL);
            quiet = 1'b0;
        end

        drain();
        $display("sent %0d characters in %0d strings over %0d base settings",
                 chars_sent, strings_sent, base_settings);
        $display("checked %0d ranges, %0d format errors and %0d empty strings",
                 ranges, errors, empties);
        if (mismatches == 0) begin
            $display("PASS numeric_range_list_parser");
        end else begin
            $display("FAIL numeric_range_list_parser");
        end
        $finish;
    end

endmodule

[numeric_range_list_parser.f]
rtl/core/nrl_pkg.sv
rtl/core/nrl_accum.sv
rtl/core/numeric_range_list_parser.sv
tb/sv/nrl_range_checker.sv
tb/sv/tb.sv
